// File: src/frl_pkg.sv
// shared types and constants for the frame rms level unit
package frl_pkg;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 13;
  localparam int unsigned LevelW  = 24;
  localparam int unsigned SqW     = 31;
  localparam int unsigned SumW    = 43;

  // frame length limit
  localparam int unsigned MaxFrame = 4096;

  // long division of sum * 2^16, one quotient bit a cycle
  localparam int unsigned FracW    = 16;
  localparam int unsigned DivSteps = SumW + FracW;
  localparam int unsigned DivRemW  = CountW;

  // square root, two radicand bits a cycle
  localparam int unsigned SqrtSteps = LevelW;
  localparam int unsigned SqrtTop   = 2 * SqrtSteps - 1;
  localparam int unsigned SqRemW    = LevelW + 2;

  localparam int unsigned StepW = $clog2(DivSteps);

  // frame queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QLevelW    = $clog2(QueueDepth + 1);

  // one finished frame handed to the back end
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    logic              too_long;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } frame_push_t;

  // back end sequencer
  typedef enum logic [3:0] {
    BackIdle = 4'b0001,
    BackDiv  = 4'b0010,
    BackSqrt = 4'b0100,
    BackDone = 4'b1000
  } back_state_e;

endpackage

// File: src/frl_if.sv
// valid/ready channel interfaces for samples and frame results
interface frl_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [frl_pkg::SampleW-1:0] sample;
  logic                              frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface frl_out_if;
  logic                         valid;
  logic                         ready;
  logic [frl_pkg::LevelW-1:0]   rms_level;
  logic [frl_pkg::CountW-1:0]   frame_count;
  logic                         too_long;

  modport source (output valid, output rms_level, output frame_count, output too_long,
                  input ready);
  modport sink   (input valid, input rms_level, input frame_count, input too_long,
                  output ready);
endinterface

// File: src/frl_front.sv
// sample front end: squares, counts and sums one sample a cycle while the queue has room
module frl_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [frl_pkg::SampleW-1:0] sample_i,
  input  logic                              frame_end_i,
  input  logic [frl_pkg::QLevelW-1:0]       q_level_i,
  output frl_pkg::frame_push_t              push_o
);

  logic                        accept;
  logic [frl_pkg::SampleW-1:0] mag;
  logic                        room;
  logic [frl_pkg::CountW-1:0]  tally_q, tally_d, tally_inc;
  logic                        ovf_q, ovf_d;

  logic                        a_valid_q, a_last_q, a_add_q, a_ovf_q;
  logic [frl_pkg::SqW-1:0]     a_sq_q;
  logic [frl_pkg::CountW-1:0]  a_count_q;

  logic [frl_pkg::SumW-1:0]    sum_q, sum_next;
  logic                        pending;
  logic [frl_pkg::QLevelW:0]   used;

  // queue space, counting a frame end still in the sum stage
  assign pending = a_valid_q & a_last_q;
  assign used    = {1'b0, q_level_i} + {{frl_pkg::QLevelW{1'b0}}, pending};
  assign ready_o = used < (frl_pkg::QLevelW+1)'(frl_pkg::QueueDepth);
  assign accept  = valid_i & ready_o;

  // magnitude of the sample, -32768 maps to 32768
  assign mag = sample_i[frl_pkg::SampleW-1] ? (~sample_i + frl_pkg::SampleW'(1))
                                            : sample_i;

  assign room      = tally_q < frl_pkg::CountW'(frl_pkg::MaxFrame);
  assign tally_inc = tally_q + frl_pkg::CountW'(1);

  // tally and overflow tracking
  always_comb begin
    tally_d = tally_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (frame_end_i) begin
        tally_d = '0;
        ovf_d   = 1'b0;
      end else if (room) begin
        tally_d = tally_inc;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q   <= '0;
      ovf_q     <= 1'b0;
      a_valid_q <= 1'b0;
      a_last_q  <= 1'b0;
    end else begin
      tally_q   <= tally_d;
      ovf_q     <= ovf_d;
      a_valid_q <= accept;
      if (accept) begin
        a_last_q <= frame_end_i;
      end
    end
  end

  // square stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sq_q    <= frl_pkg::SqW'(mag * mag);
      a_add_q   <= room;
      a_count_q <= room ? tally_inc : tally_q;
      a_ovf_q   <= ovf_q | ~room;
    end
  end

  // sum stage
  assign sum_next = sum_q + (a_add_q ? {{(frl_pkg::SumW-frl_pkg::SqW){1'b0}}, a_sq_q}
                                     : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (a_valid_q) begin
      sum_q <= a_last_q ? '0 : sum_next;
    end
  end

  assign push_o.valid        = pending;
  assign push_o.rec.sum      = sum_next;
  assign push_o.rec.count    = a_count_q;
  assign push_o.rec.too_long = a_ovf_q;

endmodule

// File: src/frl_queue.sv
// short queue of finished frames between front and back
module frl_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frl_pkg::frame_push_t        push_i,
  input  logic                        pop_i,
  output frl_pkg::frame_rec_t         head_o,
  output logic [frl_pkg::QLevelW-1:0] level_o
);

  frl_pkg::frame_rec_t            mem_q [frl_pkg::QueueDepth];
  logic [frl_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [frl_pkg::QLevelW-1:0]    level_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + frl_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + frl_pkg::QPtrW'(1);
      end
      if (push_i.valid && !pop_i) begin
        level_q <= level_q + frl_pkg::QLevelW'(1);
      end else if (!push_i.valid && pop_i) begin
        level_q <= level_q - frl_pkg::QLevelW'(1);
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

// File: src/frl_back.sv
// back end: divides sum by count, takes the square root, holds the result
module frl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frl_pkg::frame_rec_t         head_i,
  input  logic [frl_pkg::QLevelW-1:0] q_level_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [frl_pkg::LevelW-1:0]  rms_level_o,
  output logic [frl_pkg::CountW-1:0]  frame_count_o,
  output logic                        too_long_o
);

  frl_pkg::back_state_e            state_q, state_d;
  logic [frl_pkg::StepW-1:0]       step_q, step_d;
  logic [frl_pkg::DivSteps-1:0]    dq_q, dq_d;
  logic [frl_pkg::DivRemW-1:0]     rem_q, rem_d;
  logic [frl_pkg::CountW-1:0]      div_q;
  logic [frl_pkg::LevelW-1:0]      root_q, root_d;
  logic [frl_pkg::SqRemW-1:0]      srem_q, srem_d;
  logic                            ovf_q;
  logic                            load_out;

  // division step
  logic [frl_pkg::DivRemW:0]       trial, diff;
  logic                            div_ge;
  // square root step
  logic [frl_pkg::SqRemW+1:0]      s_ext, s_trial, s_diff;
  logic                            sq_ge;

  assign trial  = {rem_q, dq_q[frl_pkg::DivSteps-1]};
  assign diff   = trial - {1'b0, div_q};
  assign div_ge = trial >= {1'b0, div_q};

  assign s_ext   = {srem_q, dq_q[frl_pkg::SqrtTop -: 2]};
  assign s_trial = {2'b00, root_q, 2'b01};
  assign s_diff  = s_ext - s_trial;
  assign sq_ge   = s_ext >= s_trial;

  assign pop_o    = (state_q == frl_pkg::BackIdle) && (q_level_i != '0);
  assign load_out = (state_q == frl_pkg::BackDone) && (!valid_o || ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    root_d  = root_q;
    srem_d  = srem_q;
    case (state_q)
      frl_pkg::BackIdle: begin
        if (pop_o) begin
          dq_d   = {head_i.sum, {frl_pkg::FracW{1'b0}}};
          rem_d  = '0;
          root_d = '0;
          step_d = frl_pkg::StepW'(frl_pkg::DivSteps - 1);
          state_d = head_i.too_long ? frl_pkg::BackDone : frl_pkg::BackDiv;
        end
      end
      frl_pkg::BackDiv: begin
        rem_d = div_ge ? diff[frl_pkg::DivRemW-1:0] : trial[frl_pkg::DivRemW-1:0];
        dq_d  = {dq_q[frl_pkg::DivSteps-2:0], div_ge};
        if (step_q == '0) begin
          srem_d  = '0;
          step_d  = frl_pkg::StepW'(frl_pkg::SqrtSteps - 1);
          state_d = frl_pkg::BackSqrt;
        end else begin
          step_d = step_q - frl_pkg::StepW'(1);
        end
      end
      frl_pkg::BackSqrt: begin
        srem_d = sq_ge ? s_diff[frl_pkg::SqRemW-1:0] : s_ext[frl_pkg::SqRemW-1:0];
        root_d = {root_q[frl_pkg::LevelW-2:0], sq_ge};
        dq_d   = {dq_q[frl_pkg::DivSteps-3:0], 2'b00};
        if (step_q == '0) begin
          state_d = frl_pkg::BackDone;
        end else begin
          step_d = step_q - frl_pkg::StepW'(1);
        end
      end
      frl_pkg::BackDone: begin
        if (load_out) begin
          state_d = frl_pkg::BackIdle;
        end
      end
      default: begin
        state_d = frl_pkg::BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frl_pkg::BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    srem_q <= srem_d;
    if (pop_o) begin
      div_q <= head_i.count;
      ovf_q <= head_i.too_long;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (load_out) begin
      valid_o <= 1'b1;
    end else if (ready_i) begin
      valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rms_level_o   <= ovf_q ? '0 : root_q;
      frame_count_o <= div_q;
      too_long_o    <= ovf_q;
    end
  end

endmodule

// File: src/frame_rms_level_unit.sv
// top level of the frame rms level unit
//
//  channel  | dir | request carries                       | taken when
//  in_i     | in  | sample (s16), frame_end               | in_i.valid & in_i.ready
//  res_o    | out | rms_level (Q16.8), frame_count, too_long | res_o.valid & res_o.ready
//
// The front end takes one sample every cycle while the frame queue has room.
// The back end handles a normal frame as pop, 59 division steps, 24 square root
// steps and result load; a too-long frame goes from pop straight to result load.
// Frames shorter than that work fill the two-entry frame queue and in_i.ready drops.
// A result waiting on res_o stops the front end only once the frame queue is full.
// Reset is asynchronous, active low, and leaves all state empty.
module frame_rms_level_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  frl_in_if.sink     in_i,
  frl_out_if.source  res_o
);

  frl_pkg::frame_push_t          push;
  frl_pkg::frame_rec_t           head;
  logic [frl_pkg::QLevelW-1:0]   q_level;
  logic                          pop;

  // accumulate squares
  frl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .sample_i    (in_i.sample),
    .frame_end_i (in_i.frame_end),
    .q_level_i   (q_level),
    .push_o      (push)
  );

  // frame queue
  frl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (q_level)
  );

  // divide and square root
  frl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_level_i     (q_level),
    .pop_o         (pop),
    .valid_o       (res_o.valid),
    .ready_i       (res_o.ready),
    .rms_level_o   (res_o.rms_level),
    .frame_count_o (res_o.frame_count),
    .too_long_o    (res_o.too_long)
  );

endmodule

// File: src/frl_checker.sv
// port checker for the frame rms level unit, bound to the top level
module frl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       ready_i,
  input logic [frl_pkg::LevelW-1:0] rms_level_i,
  input logic [frl_pkg::CountW-1:0] frame_count_i,
  input logic                       too_long_i
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(rms_level_i) && $stable(frame_count_i) &&
                            $stable(too_long_i))
    else $error("result payload changed while stalled");

  // a too-long frame reports level zero at the full count
  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && too_long_i |-> rms_level_i == '0 &&
                              frame_count_i == frl_pkg::CountW'(frl_pkg::MaxFrame))
    else $error("too-long frame with wrong level or count");

  // count in range, level bounded by full scale
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> frame_count_i != '0 &&
                frame_count_i <= frl_pkg::CountW'(frl_pkg::MaxFrame) &&
                rms_level_i <= frl_pkg::LevelW'(24'h800000))
    else $error("result field out of range");

endmodule

bind frame_rms_level_unit frl_checker u_frl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (res_o.valid),
  .ready_i       (res_o.ready),
  .rms_level_i   (res_o.rms_level),
  .frame_count_i (res_o.frame_count),
  .too_long_i    (res_o.too_long)
);

// File: tb/frame_rms_level_unit_tb.sv
// self-checking testbench for the frame rms level unit
module frame_rms_level_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 5000000;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned TailQuiet = 300;
  localparam int unsigned SettleCycles = 400;
  localparam int unsigned MaxReports = 10;

  // one sample request as queued for the driver
  typedef struct {
    logic signed [frl_pkg::SampleW-1:0] sample;
    logic                               frame_end;
    bit                                 drain;
  } sample_req_t;

  // one frame result as the block should report it
  typedef struct {
    logic [frl_pkg::LevelW-1:0] level;
    logic [frl_pkg::CountW-1:0] count;
    logic                       too_long;
  } rms_result_t;

  // sample styles for random frames
  typedef enum int unsigned {
    StyleWide,
    StyleEdges,
    StyleQuiet,
    StyleFullNeg
  } sample_style_e;

  logic clk_i;
  logic rst_n;

  frl_in_if  in_ch ();
  frl_out_if res_ch ();

  frame_rms_level_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  sample_req_t pending_reqs[$];
  rms_result_t rms_expected[$];
  sample_req_t next_req;
  rms_result_t oldest_want;

  // running frame state of the prediction
  logic [frl_pkg::SumW-1:0]   acc_sum;
  logic [frl_pkg::CountW-1:0] acc_tally;
  logic                       acc_overflow;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap;
  int unsigned take_stall;
  bit          calm;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // floor of the square root, two bits of the radicand at a time
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // accumulate one accepted sample, queue the frame result on its last one
  task automatic account_sample(logic signed [frl_pkg::SampleW-1:0] s, logic last);
    logic [frl_pkg::SampleW-1:0] mag;
    logic [frl_pkg::SumW-1:0]    sq;
    logic [63:0]                 scaled;
    rms_result_t                 res;
    mag = s[frl_pkg::SampleW-1] ? (~s + 1'b1) : s;
    sq  = mag * mag;
    if (acc_tally < frl_pkg::MaxFrame) begin
      acc_sum   = acc_sum + sq;
      acc_tally = acc_tally + 1'b1;
    end else begin
      acc_overflow = 1'b1;
    end
    if (last) begin
      if (acc_overflow || acc_tally == 0) begin
        res.level = '0;
      end else begin
        scaled    = {21'b0, acc_sum} << frl_pkg::FracW;
        scaled    = scaled / {51'b0, acc_tally};
        res.level = frl_pkg::LevelW'(floor_root(scaled));
      end
      res.count    = acc_tally;
      res.too_long = acc_overflow;
      rms_expected.push_back(res);
      acc_sum      = '0;
      acc_tally    = '0;
      acc_overflow = 1'b0;
    end
  endtask

  function automatic logic signed [frl_pkg::SampleW-1:0] pick_sample(sample_style_e style);
    logic signed [frl_pkg::SampleW-1:0] s;
    case (style)
      StyleEdges: begin
        case ($urandom_range(0, 3))
          0: s = 16'sh8000;
          1: s = 16'sh7fff;
          2: s = 16'sh0000;
          default: s = 16'shffff;
        endcase
      end
      StyleQuiet: s = $signed(16'($urandom_range(0, 64))) - 16'sd32;
      StyleFullNeg: s = 16'sh8000;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic push_sample(logic signed [frl_pkg::SampleW-1:0] s, logic last, bit drain);
    sample_req_t r;
    r.sample    = s;
    r.frame_end = last;
    r.drain     = drain;
    pending_reqs.push_back(r);
  endtask

  task automatic add_frame(int unsigned len, sample_style_e style, bit drain);
    for (int unsigned i = 0; i < len; i++)
      push_sample(pick_sample(style), i == len - 1, drain && i == 0);
  endtask

  task automatic note_fault(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%0t: %s", $realtime, msg);
  endtask

  // sample driver, fed from the pending queue
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample    <= '0;
      in_ch.frame_end <= 1'b0;
      send_gap        <= 0;
      acc_sum         = '0;
      acc_tally       = '0;
      acc_overflow    = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) account_sample(in_ch.sample, in_ch.frame_end);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (pending_reqs[0].drain && rms_expected.size() != 0) begin
          // hold off until every frame in flight has reported
          in_ch.valid <= 1'b0;
        end else if (!calm && pending_reqs.size() > TailQuiet &&
                     $urandom_range(0, 7) == 0) begin
          send_gap    <= $urandom_range(0, 16);
          in_ch.valid <= 1'b0;
        end else begin
          next_req        = pending_reqs.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.sample    <= next_req.sample;
          in_ch.frame_end <= next_req.frame_end;
        end
      end
    end
  end

  // result receiver with random stall bursts and calm stretches
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      take_stall   <= 0;
      calm         <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (take_stall != 0) begin
        take_stall   <= take_stall - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && pending_reqs.size() > TailQuiet &&
                   $urandom_range(0, 9) == 0) begin
        take_stall   <= $urandom_range(0, 16);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (rms_expected.size() == 0) begin
        note_fault($sformatf("unexpected result level=%0d count=%0d too_long=%0b",
                             res_ch.rms_level, res_ch.frame_count, res_ch.too_long));
      end else begin
        oldest_want = rms_expected.pop_front();
        if (res_ch.rms_level !== oldest_want.level ||
            res_ch.frame_count !== oldest_want.count ||
            res_ch.too_long !== oldest_want.too_long)
          note_fault($sformatf(
            "mismatch: level %0d/%0d count %0d/%0d too_long %0b/%0b (expected/actual)",
            oldest_want.level, res_ch.rms_level, oldest_want.count,
            res_ch.frame_count, oldest_want.too_long, res_ch.too_long));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("frame_rms_level_unit_tb NOT OK");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned random_count;
    int unsigned len;
    int unsigned pick;
    bit          long_done;

    rst_n = 1'b0;

    // single-sample frames at the extremes
    push_sample(16'sh8000, 1'b1, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b1, 1'b0);
    push_sample(16'sh0001, 1'b1, 1'b0);
    push_sample(16'shffff, 1'b1, 1'b0);
    // short frames with mid-frame samples
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh0001, 1'b0, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b0);
    push_sample(16'shffff, 1'b1, 1'b0);
    push_sample(16'sh5555, 1'b0, 1'b0);
    push_sample(16'shaaaa, 1'b1, 1'b0);
    push_sample(16'sh0000, 1'b0, 1'b0);
    push_sample(16'sh0000, 1'b1, 1'b0);

    // random frames, mostly short, with a full and a too-long frame midway
    random_count = 0;
    long_done    = 1'b0;
    add_frame(4, StyleWide, 1'b1);
    while (random_count < RandomItems) begin
      if (!long_done && random_count >= RandomItems / 2) begin
        add_frame(frl_pkg::MaxFrame, StyleFullNeg, 1'b1);
        add_frame(frl_pkg::MaxFrame + 1, StyleWide, 1'b0);
        long_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) len = $urandom_range(1, 3);
      else if (pick < 8) len = $urandom_range(4, 32);
      else len = $urandom_range(33, 120);
      pick = $urandom_range(0, 9);
      add_frame(len, pick < 5 ? StyleWide : pick < 8 ? StyleEdges : StyleQuiet,
                $urandom_range(0, 39) == 0);
      random_count += len;
    end

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    // wait for every request to be taken and every result to arrive
    while (pending_reqs.size() != 0 || in_ch.valid || rms_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && rms_expected.size() == 0) begin
      $display("frame_rms_level_unit_tb OK");
    end else begin
      $display("frame_rms_level_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/frl_pkg.sv
src/frl_if.sv
src/frl_front.sv
src/frl_queue.sv
src/frl_back.sv
src/frame_rms_level_unit.sv
src/frl_checker.sv
tb/frame_rms_level_unit_tb.sv
